/* sv/sbl_render_pkg.sv */
// Shared constants, command and state codes, and transfer payload types.
`timescale 1ns / 1ps
package sbl_render_pkg;

   localparam int MAP_ROWS     = 16;
   localparam int MAX_COLUMNS  = 16;
   localparam int TEXT_ROWS    = 5;
   localparam int LABEL_ROW    = MAP_ROWS - 1;
   localparam int DATA_ROWS    = MAP_ROWS - 1;
   localparam int ROW_ADDR_W   = $clog2(DATA_ROWS);
   localparam int COL_IDX_W    = $clog2(MAX_COLUMNS);
   localparam int COL_CNT_W    = $clog2(MAX_COLUMNS + 1);
   localparam int TEXT_IDX_W   = $clog2(TEXT_ROWS);
   localparam logic [7:0] LABEL_RED = 8'd156;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_LOAD   = 3'd1,
      CMD_SHIFT  = 3'd2,
      CMD_SET    = 3'd3,
      CMD_RENDER = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_FG_RED      = 3'd0,
      CSR_FG_GREEN    = 3'd1,
      CSR_FG_BLUE     = 3'd2,
      CSR_BACKGROUND  = 3'd3,
      CSR_TEXT_TOP    = 3'd4,
      CSR_ROWS_IN_USE = 3'd5,
      CSR_COLS_IN_USE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW_READ,
      ST_RMW_WRITE,
      ST_RENDER_LOAD,
      ST_RENDER_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [4:0] column_bits;
      logic       column_is_label;
      logic [3:0] row_index;
      logic [3:0] bit_index;
   } req_type;

   typedef struct packed {
      logic [7:0] led_address;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } rsp_type;

endpackage

/* sv/scrolling_bitmap_led_matrix_render.sv */
// Scrolling bitmap LED matrix renderer: bitmap store, command sequencer, pixel output.
`timescale 1ns / 1ps
// Holds a 15-row pixel bitmap in a registered-read RAM plus a label plane in
// flops. Clear and label-plane updates finish in the accept cycle. Load column
// and shift left read, then write back, each text row in the map and skip the
// rows outside it. Set bit reads and writes back one row. Render row fetches
// the row from RAM, then emits one pixel per cycle while the result side does
// not stall; the single output register sets that pace.
// One command is worked on at a time; req_stall is high while it runs.
module scrolling_bitmap_led_matrix_render (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sbl_render_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sbl_render_pkg::rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [7:0]             csr_wdata
);
   import sbl_render_pkg::*;

   logic [MAX_COLUMNS-1:0] mem [0:DATA_ROWS-1];
   logic [MAX_COLUMNS-1:0] mem_rd_ff;
   logic [DATA_ROWS-1:0]   row_valid_ff;
   logic [MAX_COLUMNS-1:0] label_ff;

   logic [7:0] fg_red_ff, fg_green_ff, fg_blue_ff, background_ff;
   logic [3:0] text_top_ff, rows_in_use_ff;
   logic [4:0] columns_in_use_ff;

   state_type state_ff, state_in;
   req_type   cmd_ff;
   logic [TEXT_IDX_W-1:0] idx_ff;
   logic [ROW_ADDR_W-1:0] addr_ff;
   logic [MAX_COLUMNS-1:0] line_ff;
   logic [7:0] base_ff;
   logic [COL_CNT_W-1:0] cols_ff;
   logic [COL_CNT_W-1:0] col_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic req_accept, slot_free;
   logic rd_en, wr_en, emit;
   logic [ROW_ADDR_W-1:0] rd_addr;
   logic [4:0] rmw_row;
   logic rmw_last;
   logic [COL_CNT_W-1:0] cols_sat;
   logic render_ok;
   logic [MAX_COLUMNS-1:0] old_row, new_row;
   logic [COL_CNT_W-1:0] pos_full, off;
   logic [COL_IDX_W-1:0] pos;
   logic [8:0] product;
   logic pix_data, pix_label;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign cols_sat = (columns_in_use_ff > COL_CNT_W'(MAX_COLUMNS)) ?
                     COL_CNT_W'(MAX_COLUMNS) : COL_CNT_W'(columns_in_use_ff);
   assign render_ok = (req_data.row_index < rows_in_use_ff) &&
                      (32'(req_data.row_index) < DATA_ROWS) && (cols_sat != '0);

   assign rmw_row  = (cmd_ff.command == CMD_SET) ? {1'b0, cmd_ff.row_index} :
                     ({1'b0, text_top_ff} + 5'(idx_ff));
   assign rmw_last = (cmd_ff.command == CMD_SET) ||
                     (idx_ff == TEXT_IDX_W'(TEXT_ROWS - 1));

   assign old_row = row_valid_ff[addr_ff] ? mem_rd_ff : '0;
   always_comb begin
      case (cmd_ff.command)
         CMD_LOAD:  new_row = {old_row[MAX_COLUMNS-1:1], cmd_ff.column_bits[idx_ff]};
         CMD_SHIFT: new_row = {old_row[MAX_COLUMNS-2:0], 1'b0};
         default:   new_row = old_row | (MAX_COLUMNS'(1) << cmd_ff.bit_index);
      endcase
   end

   assign pos_full  = COL_CNT_W'(MAX_COLUMNS) - col_ff;
   assign pos       = pos_full[COL_IDX_W-1:0];
   assign off       = cmd_ff.row_index[0] ? (col_ff - COL_CNT_W'(1)) : (cols_ff - col_ff);
   assign product   = 9'(cols_sat) * 9'(req_data.row_index);
   assign pix_data  = line_ff[pos];
   assign pix_label = label_ff[pos];

   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = addr_ff;
      wr_en    = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.command)
                  CMD_LOAD, CMD_SHIFT: state_in = ST_RMW_READ;
                  CMD_SET: begin
                     if (32'(req_data.row_index) < DATA_ROWS) state_in = ST_RMW_READ;
                  end
                  CMD_RENDER: begin
                     if (render_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_data.row_index[ROW_ADDR_W-1:0];
                        state_in = ST_RENDER_LOAD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW_READ: begin
            if (32'(rmw_row) < DATA_ROWS) begin
               rd_en    = 1'b1;
               rd_addr  = rmw_row[ROW_ADDR_W-1:0];
               state_in = ST_RMW_WRITE;
            end else if (rmw_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RMW_WRITE: begin
            wr_en    = 1'b1;
            state_in = rmw_last ? ST_IDLE : ST_RMW_READ;
         end
         ST_RENDER_LOAD: state_in = ST_RENDER_EMIT;
         ST_RENDER_EMIT: begin
            if (slot_free) begin
               emit = 1'b1;
               if (col_ff == cols_ff) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // bitmap RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= new_row;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         label_ff     <= '0;
      end else begin
         if (req_accept && req_data.command == CMD_CLEAR) begin
            row_valid_ff <= '0;
            label_ff     <= '0;
         end else if (wr_en) begin
            row_valid_ff[addr_ff] <= 1'b1;
         end
         if (req_accept) begin
            case (req_data.command)
               CMD_LOAD:  label_ff[0] <= req_data.column_is_label;
               CMD_SHIFT: label_ff <= {label_ff[MAX_COLUMNS-2:0], 1'b0};
               CMD_SET: begin
                  if (32'(req_data.row_index) == LABEL_ROW) begin
                     label_ff[req_data.bit_index] <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_red_ff         <= 8'd0;
         fg_green_ff       <= 8'd0;
         fg_blue_ff        <= 8'd0;
         background_ff     <= 8'd40;
         text_top_ff       <= 4'd0;
         rows_in_use_ff    <= 4'd14;
         columns_in_use_ff <= 5'd15;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FG_RED:      fg_red_ff         <= csr_wdata;
            CSR_FG_GREEN:    fg_green_ff       <= csr_wdata;
            CSR_FG_BLUE:     fg_blue_ff        <= csr_wdata;
            CSR_BACKGROUND:  background_ff     <= csr_wdata;
            CSR_TEXT_TOP:    text_top_ff       <= csr_wdata[3:0];
            CSR_ROWS_IN_USE: rows_in_use_ff    <= csr_wdata[3:0];
            CSR_COLS_IN_USE: columns_in_use_ff <= csr_wdata[4:0];
            default:         fg_red_ff         <= fg_red_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_data;
         cols_ff <= cols_sat;
         base_ff <= product[7:0];
      end
      if (req_accept) begin
         idx_ff <= '0;
      end else if ((state_ff == ST_RMW_WRITE ||
                   (state_ff == ST_RMW_READ && state_in == ST_RMW_READ)) && !rmw_last) begin
         idx_ff <= idx_ff + TEXT_IDX_W'(1);
      end
      if (rd_en) begin
         addr_ff <= rd_addr;
      end
      if (state_ff == ST_RENDER_LOAD) begin
         line_ff <= old_row;
         col_ff  <= COL_CNT_W'(1);
      end else if (emit) begin
         col_ff <= col_ff + COL_CNT_W'(1);
      end
      if (emit) begin
         rsp_ff.led_address <= base_ff + 8'(off);
         rsp_ff.last        <= (col_ff == cols_ff);
         if (!pix_data) begin
            rsp_ff.red   <= background_ff;
            rsp_ff.green <= background_ff;
            rsp_ff.blue  <= background_ff;
         end else if (pix_label) begin
            rsp_ff.red   <= LABEL_RED;
            rsp_ff.green <= 8'd0;
            rsp_ff.blue  <= 8'd0;
         end else begin
            rsp_ff.red   <= fg_red_ff;
            rsp_ff.green <= fg_green_ff;
            rsp_ff.blue  <= fg_blue_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule
